/* hdl/efws_pkg.sv */
// Shared constants, command/status types and controller states for the worker scheduler.
package efws_pkg;

  // Worker pool size and field widths
  localparam int NUM_WORKERS = 16;
  localparam int TIME_W      = 64;
  localparam int DUR_W       = 32;
  localparam int OUT_IDX_W   = 4;
  localparam int CFG_W       = 5;
  localparam int CFG_RESET   = 16;

  // Worker index width and active-count width (count can hold NUM_WORKERS itself)
  localparam int IDX_W = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
  localparam int CNT_W = $clog2(NUM_WORKERS + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;    // latch a new job and seed the scan with worker 0
    logic scan;    // compare one more worker against the running minimum
    logic commit;  // update the chosen worker and load the result register
  } efws_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic single;     // only one worker active, no scan needed
    logic scan_last;  // the worker under compare is the last active one
    logic out_busy;   // result register still holds an untaken result
  } efws_sts_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } efws_state_t;

endpackage

/* hdl/earliest_free_worker_scheduler.sv */
// Earliest-free worker scheduler: a job holds the block from its transfer in through the
// scan, if any, and the commit step until the next transfer in can be taken, including any
// wait of the commit step for an untaken result. Its result shows on out_valid in the cycle
// after the commit step. Worker 0 is taken as the running minimum at the transfer in, the
// other active workers are compared against it one per cycle, and the commit step does the
// saturating update and the load of the result register. in_ready is high only while no
// job is in work. A result still waiting in the output register does not block the next
// transfer in; only the commit step of the following job waits for it to be taken. Ties
// go to the lowest worker index. The active worker count is clamped to 1..16 and should
// be written only while the block is idle.
module earliest_free_worker_scheduler (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [efws_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [efws_pkg::DUR_W-1:0]     in_job_duration,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [efws_pkg::OUT_IDX_W-1:0] out_assigned_worker,
  output logic [efws_pkg::TIME_W-1:0]    out_start_time
);
  import efws_pkg::*;

  efws_cmd_t cmd;
  efws_sts_t sts;

  // Sequence one job at a time
  efws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Free times, scan and result register
  efws_dpath u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_job_duration     (in_job_duration),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .out_assigned_worker (out_assigned_worker),
    .out_start_time      (out_start_time),
    .cmd                 (cmd),
    .sts                 (sts)
  );

endmodule

/* hdl/efws_ctrl.sv */
// Controller state machine: sequences accept, minimum scan and commit of one job.
module efws_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  efws_pkg::efws_sts_t sts,
  output efws_pkg::efws_cmd_t cmd
);
  import efws_pkg::*;

  efws_state_t state_r;
  efws_state_t state_nxt;

  // Hold the current state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance through scan and commit
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.single ? ST_COMMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (!sts.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Drive handshake and datapath commands
  always_comb begin
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.scan   = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_COMMIT: begin
        cmd.commit = !sts.out_busy;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

/* hdl/efws_dpath.sv */
// Datapath: free-time registers, running-minimum scan, saturating update and result register.
module efws_dpath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [efws_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic [efws_pkg::DUR_W-1:0]     in_job_duration,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [efws_pkg::OUT_IDX_W-1:0] out_assigned_worker,
  output logic [efws_pkg::TIME_W-1:0]    out_start_time,
  input  efws_pkg::efws_cmd_t            cmd,
  output efws_pkg::efws_sts_t            sts
);
  import efws_pkg::*;

  logic [CFG_W-1:0]     active_workers_r;
  logic [TIME_W-1:0]    free_time_r [NUM_WORKERS];
  logic [DUR_W-1:0]     dur_r;
  logic [IDX_W-1:0]     idx_r;
  logic [IDX_W-1:0]     best_idx_r;
  logic [TIME_W-1:0]    best_time_r;
  logic                 out_valid_r;
  logic [OUT_IDX_W-1:0] out_worker_r;
  logic [TIME_W-1:0]    out_start_r;

  logic [CMP_W-1:0]         cfg_ext;
  logic [CNT_W-1:0]         act_cnt;
  logic [CNT_W-1:0]         last_idx;
  logic [TIME_W-1:0]        cand_time;
  logic                     cand_less;
  logic [TIME_W:0]          sum_wide;
  logic [TIME_W-1:0]        sum_sat;
  logic [IDX_W+OUT_IDX_W-1:0] best_ext;

  // Hold the active worker count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_workers_r <= CFG_W'(CFG_RESET);
    end else if (cfg_wr_en) begin
      active_workers_r <= cfg_wr_data;
    end
  end

  // Clamp the count to 1..NUM_WORKERS
  always_comb begin
    cfg_ext = CMP_W'(active_workers_r);
    if (cfg_ext == '0) begin
      act_cnt = CNT_W'(1);
    end else if (cfg_ext > CMP_W'(NUM_WORKERS)) begin
      act_cnt = CNT_W'(NUM_WORKERS);
    end else begin
      act_cnt = CNT_W'(cfg_ext);
    end
    last_idx = act_cnt - CNT_W'(1);
  end

  // Compare the worker under scan against the running minimum
  assign cand_time = free_time_r[idx_r];
  assign cand_less = cand_time < best_time_r;

  // Saturating free-time update
  assign sum_wide = {1'b0, best_time_r} + (TIME_W + 1)'(dur_r);
  assign sum_sat  = sum_wide[TIME_W] ? {TIME_W{1'b1}} : sum_wide[TIME_W-1:0];

  // Mask the worker index to the result field width
  assign best_ext = {{OUT_IDX_W{1'b0}}, best_idx_r};

  // Status back to the controller
  always_comb begin
    sts.single    = (act_cnt == CNT_W'(1));
    sts.scan_last = (CNT_W'(idx_r) == last_idx);
    sts.out_busy  = out_valid_r && !out_ready;
  end

  // Seed and advance the scan
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dur_r       <= in_job_duration;
      best_idx_r  <= '0;
      best_time_r <= free_time_r[0];
      idx_r       <= IDX_W'(1);
    end else if (cmd.scan) begin
      if (cand_less) begin
        best_idx_r  <= idx_r;
        best_time_r <= cand_time;
      end
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  // Advance the chosen worker's free time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_WORKERS; i++) begin
        free_time_r[i] <= '0;
      end
    end else if (cmd.commit) begin
      free_time_r[best_idx_r] <= sum_sat;
    end
  end

  // Result register: set on commit, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_worker_r <= best_ext[OUT_IDX_W-1:0];
      out_start_r  <= best_time_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_assigned_worker = out_worker_r;
  assign out_start_time      = out_start_r;

endmodule

/* hdl/efws_checker.sv */
// Port-level checker for the worker scheduler and its bind to the top level.
module efws_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [efws_pkg::OUT_IDX_W-1:0] out_assigned_worker,
  input logic [efws_pkg::TIME_W-1:0]    out_start_time
);
  import efws_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_assigned_worker)
      && $stable(out_start_time))
    else $error("stalled result changed or dropped");

  // A transfer in makes the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready stayed high after a transfer in");

  // No result appears in the cycle right after a transfer in
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

  // A new result appears only while a job is in work
  a_result_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared with no job in work");

endmodule

bind earliest_free_worker_scheduler efws_checker u_efws_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_assigned_worker (out_assigned_worker),
  .out_start_time      (out_start_time)
);

/* bench/earliest_free_worker_scheduler_tb.sv */
// Self-checking testbench for the earliest-free worker scheduler.
`timescale 1ns / 100ps

module earliest_free_worker_scheduler_tb;
  import efws_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 6;
  localparam int RANDOM_JOBS   = 1250;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_PRINTS    = 30;

  typedef enum logic {ROW_JOB, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t               kind;
    logic [DUR_W-1:0]        value;
    bit                      typed;
    logic [OUT_IDX_W-1:0]    want_worker;
    logic [TIME_W-1:0]       want_start;
  } stim_row_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] worker;
    logic [TIME_W-1:0]    start;
  } assignment_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_W-1:0]     cfg_wr_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [DUR_W-1:0]     in_job_duration;
  logic                 out_valid;
  logic                 out_ready;
  logic [OUT_IDX_W-1:0] out_assigned_worker;
  logic [TIME_W-1:0]    out_start_time;

  // Scheduler mirror: free time per worker and the active-count register
  logic [TIME_W-1:0]    free_time [NUM_WORKERS];
  logic [CFG_W-1:0]     worker_count_reg;

  assignment_t          pending_assignments [$];
  stim_row_t            directed_rows [$];
  int                   mismatch_count;
  int                   jobs_sent;
  int                   results_seen;
  int                   settings_used;
  bit                   gaps_on;

  earliest_free_worker_scheduler DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_job_duration     (in_job_duration),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_assigned_worker (out_assigned_worker),
    .out_start_time      (out_start_time)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // Pick the earliest-free active worker, report its start time, advance it
  function automatic void place_job(input logic [DUR_W-1:0] dur,
                                    output logic [OUT_IDX_W-1:0] worker,
                                    output logic [TIME_W-1:0] start);
    int          n;
    int          best;
    logic [TIME_W:0] sum;
    n = int'(worker_count_reg);
    if (n == 0) n = 1;
    if (n > NUM_WORKERS) n = NUM_WORKERS;
    best = 0;
    for (int i = 1; i < n; i++) begin
      if (free_time[i] < free_time[best]) best = i;
    end
    start = free_time[best];
    sum = {1'b0, start} + {{(TIME_W + 1 - DUR_W){1'b0}}, dur};
    free_time[best] = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    worker = best[OUT_IDX_W-1:0];
  endfunction

  // Gap length: mostly none or short, a few long enough to span a full scan
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 16);
    return $urandom_range(17, 60);
  endfunction

  // Durations: many tiny ones to force ties, plus full-range and extremes
  function automatic logic [DUR_W-1:0] pick_duration();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom_range(0, 15);
    if (r < 7) return $urandom;
    if (r == 7) return '0;
    if (r == 8) return '1;
    return 32'h1 << $urandom_range(0, DUR_W - 1);
  endfunction

  function automatic logic [CFG_W-1:0] pick_worker_count();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return CFG_W'(1);
    if (r == 2) return CFG_W'(NUM_WORKERS);
    if (r == 3) return '1;
    if (r == 4) return CFG_W'($urandom_range(NUM_WORKERS + 1, 30));
    return CFG_W'($urandom_range(1, NUM_WORKERS));
  endfunction

  task automatic report_mismatch(input string what, input logic [TIME_W-1:0] got,
                                 input logic [TIME_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("ERROR at %0t: %s got %0h want %0h", $time, what, got, want);
  endtask

  task automatic add_row(input row_kind_t kind, input logic [DUR_W-1:0] value,
                         input bit typed, input logic [OUT_IDX_W-1:0] worker,
                         input logic [TIME_W-1:0] start);
    stim_row_t row;
    row.kind        = kind;
    row.value       = value;
    row.typed       = typed;
    row.want_worker = worker;
    row.want_start  = start;
    directed_rows = {directed_rows, row};
  endtask

  // Drop valid and hold until every expected result has come back
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_assignments.size() != 0) @(posedge clk);
  endtask

  // Write the active-count register while the block is idle
  task automatic apply_worker_count(input logic [CFG_W-1:0] value);
    wait_drain();
    cfg_wr_en        <= 1'b1;
    cfg_wr_data      <= value;
    worker_count_reg  = value;
    @(posedge clk);
    cfg_wr_en        <= 1'b0;
    settings_used++;
  endtask

  // Offer one job, hold it until the transfer, then record what it should give
  task automatic send_job(input logic [DUR_W-1:0] dur, input bit typed,
                          input logic [OUT_IDX_W-1:0] want_worker,
                          input logic [TIME_W-1:0] want_start);
    int                   gap;
    logic [OUT_IDX_W-1:0] w;
    logic [TIME_W-1:0]    s;
    assignment_t          a;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_job_duration <= dur;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    place_job(dur, w, s);
    if (typed) begin
      w = want_worker;
      s = want_start;
    end
    a.worker = w;
    a.start  = s;
    pending_assignments = {pending_assignments, a};
    jobs_sent++;
  endtask

  // Result side: check each transfer out and stall at random
  initial begin : result_side
    int          stall_left;
    assignment_t a;
    stall_left = 0;
    out_ready  = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_assignments.size() == 0) begin
          report_mismatch("result with no job waiting", out_start_time, '0);
        end else begin
          a = pending_assignments.pop_front();
          if (out_assigned_worker !== a.worker)
            report_mismatch("assigned_worker", TIME_W'(out_assigned_worker),
                            TIME_W'(a.worker));
          if (out_start_time !== a.start)
            report_mismatch("start_time", out_start_time, a.start);
        end
      end
      if (stall_left == 0 && gaps_on && $urandom_range(0, 3) == 0)
        stall_left = pick_gap();
      out_ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
      @(posedge clk);
    end
  end

  // Watchdog: end the run if nothing transfers for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("earliest_free_worker_scheduler_tb failed");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    int phase_jobs;
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    in_valid        = 1'b0;
    in_job_duration = '0;
    mismatch_count  = 0;
    jobs_sent       = 0;
    results_seen    = 0;
    settings_used   = 0;
    gaps_on         = 1'b1;
    worker_count_reg = CFG_W'(CFG_RESET);
    for (int i = 0; i < NUM_WORKERS; i++) free_time[i] = '0;

    // Directed rows: all ties after reset, then clamped counts and extremes
    add_row(ROW_JOB, 32'h0,        1'b1, 4'd0, 64'h0);
    add_row(ROW_JOB, 32'hFFFFFFFF, 1'b1, 4'd0, 64'h0);
    add_row(ROW_JOB, 32'h1,        1'b1, 4'd1, 64'h0);
    add_row(ROW_JOB, 32'h5,        1'b1, 4'd2, 64'h0);
    add_row(ROW_CFG, 32'd1,        1'b0, 4'd0, 64'h0);
    add_row(ROW_JOB, 32'h7,        1'b1, 4'd0, 64'hFFFFFFFF);
    add_row(ROW_CFG, 32'd0,        1'b0, 4'd0, 64'h0);
    add_row(ROW_JOB, 32'hAAAAAAAA, 1'b1, 4'd0, 64'h1_0000_0006);
    add_row(ROW_CFG, 32'd31,       1'b0, 4'd0, 64'h0);
    add_row(ROW_JOB, 32'h3,        1'b1, 4'd3, 64'h0);
    add_row(ROW_CFG, 32'd2,        1'b0, 4'd0, 64'h0);
    add_row(ROW_JOB, 32'h55555555, 1'b1, 4'd1, 64'h1);
    add_row(ROW_JOB, 32'h2,        1'b0, 4'd0, 64'h0);
    add_row(ROW_CFG, 32'd17,       1'b0, 4'd0, 64'h0);
    add_row(ROW_JOB, 32'h80000000, 1'b0, 4'd0, 64'h0);
    add_row(ROW_JOB, 32'h0,        1'b0, 4'd0, 64'h0);
    add_row(ROW_JOB, 32'hFFFFFFFF, 1'b0, 4'd0, 64'h0);
    add_row(ROW_CFG, 32'd16,       1'b0, 4'd0, 64'h0);
    add_row(ROW_JOB, 32'h9,        1'b0, 4'd0, 64'h0);
    add_row(ROW_JOB, 32'h12345678, 1'b0, 4'd0, 64'h0);
    add_row(ROW_CFG, 32'd5,        1'b0, 4'd0, 64'h0);
    add_row(ROW_JOB, 32'h4,        1'b0, 4'd0, 64'h0);
    add_row(ROW_JOB, 32'h4,        1'b0, 4'd0, 64'h0);

    // Hold reset, then release
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG)
        apply_worker_count(directed_rows[i].value[CFG_W-1:0]);
      else
        send_job(directed_rows[i].value, directed_rows[i].typed,
                 directed_rows[i].want_worker, directed_rows[i].want_start);
    end

    // Random phases, each with its own worker count and idling mode
    while (jobs_sent < RANDOM_JOBS + directed_rows.size()) begin
      apply_worker_count(pick_worker_count());
      gaps_on    = ($urandom_range(0, 3) != 0);
      phase_jobs = $urandom_range(40, 120);
      repeat (phase_jobs) begin
        if ($urandom_range(0, 99) == 0) wait_drain();
        send_job(pick_duration(), 1'b0, '0, '0);
      end
    end

    // Drain and let the block settle
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("ran %0d jobs, %0d results checked, over %0d worker-count settings",
             jobs_sent, results_seen, settings_used);
    $display("%0d mismatches found", mismatch_count);
    if (mismatch_count == 0) begin
      $display("earliest_free_worker_scheduler_tb passed");
    end else begin
      $display("earliest_free_worker_scheduler_tb failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/efws_pkg.sv
hdl/efws_ctrl.sv
hdl/efws_dpath.sv
hdl/earliest_free_worker_scheduler.sv
hdl/efws_checker.sv
bench/earliest_free_worker_scheduler_tb.sv
